@@ sv/rgba8_alpha_over_blend_assert.svh @@
// Assertion macros shared by the alpha-over blend checker.
`ifndef RGBA8_ALPHA_OVER_BLEND_ASSERT_SVH
`define RGBA8_ALPHA_OVER_BLEND_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define RGBAOB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds across reset.
`define RGBAOB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/rgbaob_pkg.sv @@
// Package with types, constants and helper functions of the alpha-over blend.
package rgbaob_pkg;

    localparam int unsigned NUM_CH      = 4;
    localparam int unsigned QBITS       = 8;
    localparam int unsigned DIV_STEPS   = 2;
    localparam int unsigned DIV_STAGES  = QBITS / DIV_STEPS;
    // Two front stages, the quotient stages and two back stages.
    localparam int unsigned PIPE_DEPTH  = DIV_STAGES + 4;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [7:0] FULL_BYTE    = 8'hFF;
    localparam logic [8:0] OPACITY_ONE  = 9'd256;
    localparam logic [1:0] APOS_RESET   = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPACITY = 1'b0,
        CFG_APOS    = 1'b1
    } t_cfg_idx;

    typedef logic [7:0]                t_byte;
    typedef logic [NUM_CH-1:0][7:0]    t_px;
    typedef logic [NUM_CH-1:0][8:0]    t_td;

    typedef struct packed {
        logic [8:0] opacity;
        logic [1:0] apos;
    } t_cfg;

    // Front stages to quotient stages.
    typedef struct packed {
        logic [15:0] dvd;
        t_byte       ua;
        t_td         td;
        t_px         back;
    } t_prep;

    // One quotient stage, carrying the pixel data along.
    typedef struct packed {
        logic [15:0] rem;
        t_byte       q;
        logic        zero;
        logic        ovf;
        t_byte       ua;
        t_td         td;
        t_px         back;
    } t_div;

    // Rounding divide by 255: (v + 1 + (v >> 8)) >> 8 with 16-bit saturation.
    function automatic t_byte down8(input logic [15:0] v);
        logic [16:0] s1;
        logic [15:0] a1;
        logic [16:0] s2;
        logic [15:0] a2;
        s1 = {1'b0, v} + 17'd1;
        a1 = s1[16] ? 16'hFFFF : s1[15:0];
        s2 = {1'b0, a1} + {9'd0, v[15:8]};
        a2 = s2[16] ? 16'hFFFF : s2[15:0];
        return a2[15:8];
    endfunction

    // Clamp a 9-bit value to one byte.
    function automatic t_byte sat8(input logic [8:0] v);
        return v[8] ? FULL_BYTE : v[7:0];
    endfunction

endpackage

@@ sv/rgbaob_in_if.sv @@
// Input channel: one source and one backdrop pixel per item.
interface rgbaob_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_ch0;
    logic [7:0] src_ch1;
    logic [7:0] src_ch2;
    logic [7:0] src_ch3;
    logic [7:0] back_ch0;
    logic [7:0] back_ch1;
    logic [7:0] back_ch2;
    logic [7:0] back_ch3;

    modport source (
        output valid, src_ch0, src_ch1, src_ch2, src_ch3,
        output back_ch0, back_ch1, back_ch2, back_ch3,
        input  ready
    );
    modport sink (
        input  valid, src_ch0, src_ch1, src_ch2, src_ch3,
        input  back_ch0, back_ch1, back_ch2, back_ch3,
        output ready
    );
endinterface

@@ sv/rgbaob_out_if.sv @@
// Output channel: one blended pixel per item.
interface rgbaob_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_ch3;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_ch3,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_ch3,
        output ready
    );
endinterface

@@ sv/rgbaob_prep.sv @@
// Front two stages: scaled source alpha, premix terms, union alpha and dividend.
module rgbaob_prep import rgbaob_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_px   i_src,
    input  t_px   i_back,
    output t_prep o_prep
);

    typedef struct packed {
        t_byte                      as;
        t_byte                      ab;
        logic [NUM_CH-1:0][15:0]    p_hi;
        logic [NUM_CH-1:0][15:0]    p_lo;
        t_px                        back;
    } t_s1;

    t_s1   n_s1, r_s1;
    t_prep n_s2, r_s2;

    // Stage one: opacity scaling and the two source products per byte.
    always_comb begin
        logic [8:0]  op;
        logic [16:0] as_prod;
        op      = i_cfg.opacity[8] ? OPACITY_ONE : i_cfg.opacity;
        as_prod = 17'(i_src[i_cfg.apos]) * 17'(op);
        n_s1.as   = as_prod[15:8];
        n_s1.ab   = i_back[i_cfg.apos];
        n_s1.back = i_back;
        for (int k = 0; k < NUM_CH; k++) begin
            n_s1.p_hi[k] = 16'(i_back[i_cfg.apos]) * 16'(i_src[k]);
            n_s1.p_lo[k] = 16'(FULL_BYTE - i_back[i_cfg.apos]) * 16'(i_src[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    // Stage two: union alpha, premixed source per byte, and as*255.
    always_comb begin
        logic [15:0] pab;
        t_byte       d;
        logic [8:0]  sum;
        logic [8:0]  diff;
        pab  = 16'(r_s1.as) * 16'(r_s1.ab);
        d    = down8(pab);
        sum  = {1'b0, r_s1.as} + {1'b0, r_s1.ab};
        diff = sum - {1'b0, d};
        n_s2.ua   = (sum < {1'b0, d}) ? FULL_BYTE : sat8(diff);
        n_s2.dvd  = {r_s1.as, 8'd0} - {8'd0, r_s1.as};
        n_s2.back = r_s1.back;
        for (int k = 0; k < NUM_CH; k++) begin
            n_s2.td[k] = {1'b0, down8(r_s1.p_hi[k])} + {1'b0, down8(r_s1.p_lo[k])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_prep = r_s2;

endmodule

@@ sv/rgbaob_div.sv @@
// Pipelined restoring divider for the source weight, two quotient bits a stage.
module rgbaob_div import rgbaob_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_prep i_prep,
    output t_div  o_div
);

    t_div stage_in [DIV_STAGES];
    t_div n_div    [DIV_STAGES];
    t_div r_div    [DIV_STAGES];

    // First stage starts from the dividend and flags the special cases.
    always_comb begin
        stage_in[0].rem  = i_prep.dvd;
        stage_in[0].q    = '0;
        stage_in[0].zero = (i_prep.ua == 8'd0);
        stage_in[0].ovf  = (i_prep.dvd >= {i_prep.ua, 8'd0});
        stage_in[0].ua   = i_prep.ua;
        stage_in[0].td   = i_prep.td;
        stage_in[0].back = i_prep.back;
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_link
        assign stage_in[j] = r_div[j-1];
    end

    // Each stage tries the divisor shifted to its quotient bits, high bit first.
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        always_comb begin
            logic [15:0] trial;
            n_div[j] = stage_in[j];
            for (int t = 0; t < DIV_STEPS; t++) begin
                trial = {8'd0, stage_in[j].ua} << (QBITS - 1 - (j * DIV_STEPS + t));
                if (n_div[j].rem >= trial) begin
                    n_div[j].rem = n_div[j].rem - trial;
                    n_div[j].q[QBITS - 1 - (j * DIV_STEPS + t)] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div[DIV_STAGES-1];

endmodule

@@ sv/rgbaob_mix.sv @@
// Back two stages: weighted products, rounding, saturation and alpha insertion.
module rgbaob_mix import rgbaob_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_cfg i_cfg,
    input  t_div i_div,
    output t_px  o_px
);

    typedef struct packed {
        logic [NUM_CH-1:0][15:0] pa;
        logic [NUM_CH-1:0][16:0] pe;
        t_byte                   ua;
    } t_s7;

    t_s7 n_s7, r_s7;
    t_px n_out, r_out;

    // Resolve the weight, then multiply backdrop and premixed source.
    always_comb begin
        t_byte w;
        if (i_div.zero) begin
            w = 8'd0;
        end else if (i_div.ovf) begin
            w = FULL_BYTE;
        end else begin
            w = i_div.q;
        end
        n_s7.ua = i_div.ua;
        for (int k = 0; k < NUM_CH; k++) begin
            n_s7.pa[k] = 16'(FULL_BYTE - w) * 16'(i_div.back[k]);
            n_s7.pe[k] = 17'(w) * 17'(i_div.td[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s7 <= n_s7;
        end
    end

    // Round both terms, add with saturation, and put the union alpha in place.
    always_comb begin
        logic [8:0] r;
        for (int k = 0; k < NUM_CH; k++) begin
            r = {1'b0, down8(r_s7.pa[k])} + {1'b0, down8(r_s7.pe[k][15:0])};
            n_out[k] = sat8(r);
        end
        n_out[i_cfg.apos] = r_s7.ua;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_px = r_out;

endmodule

@@ sv/rgba8_alpha_over_blend.sv @@
// Top level of the RGBA8 source-over blend pipeline.
// Blends one source pixel over one backdrop pixel and accepts a new item every
// clock cycle while the output side takes results. Two front stages form the
// scaled alpha and union alpha, four stages of the restoring divider produce
// two weight bits each, and two back stages mix, round and saturate. The whole
// pipeline advances together; it holds only while a finished item waits at the
// output, so the input is ready whenever the output register is empty or being
// read. The user must write opacity and alpha position through the configuration
// port only while no item is in flight; the block does not enforce this.
module rgba8_alpha_over_blend import rgbaob_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rgbaob_in_if.sink             i_pix,
    rgbaob_out_if.source          o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg                  r_cfg;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic                  en;
    t_px                   src;
    t_px                   back;
    t_prep                 prep;
    t_div                  div_out;
    t_px                   px_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.opacity <= OPACITY_ONE;
            r_cfg.apos    <= APOS_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_OPACITY: r_cfg.opacity <= i_cfg_wdata;
                CFG_APOS:    r_cfg.apos    <= i_cfg_wdata[1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign en          = !r_vld[PIPE_DEPTH-1] || o_pix.ready;
    assign i_pix.ready = en;

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pix.valid};
        end
    end

    assign src  = {i_pix.src_ch3, i_pix.src_ch2, i_pix.src_ch1, i_pix.src_ch0};
    assign back = {i_pix.back_ch3, i_pix.back_ch2, i_pix.back_ch1, i_pix.back_ch0};

    rgbaob_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_cfg  (r_cfg),
        .i_src  (src),
        .i_back (back),
        .o_prep (prep)
    );

    rgbaob_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_prep (prep),
        .o_div  (div_out)
    );

    rgbaob_mix u_mix (
        .i_clk (i_clk),
        .i_en  (en),
        .i_cfg (r_cfg),
        .i_div (div_out),
        .o_px  (px_out)
    );

    assign o_pix.valid   = r_vld[PIPE_DEPTH-1];
    assign o_pix.out_ch0 = px_out[0];
    assign o_pix.out_ch1 = px_out[1];
    assign o_pix.out_ch2 = px_out[2];
    assign o_pix.out_ch3 = px_out[3];

endmodule

@@ sv/rgbaob_chk.sv @@
// Port-level checker for the alpha-over blend and its bind to the top level.
`include "rgba8_alpha_over_blend_assert.svh"

module rgbaob_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);

    // No item is shown in the cycle after reset.
    `RGBAOB_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // A result that is not taken stays put.
    `RGBAOB_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data), "stalled output item changed")

    // Input backpressure comes only from a waiting result.
    `RGBAOB_ASSERT_CLK(a_in_ready, i_clk, i_rst_n, i_in_ready == (!i_out_valid || i_out_ready), "input ready does not follow output state")

endmodule

bind rgba8_alpha_over_blend rgbaob_chk u_rgbaob_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_data  ({o_pix.out_ch3, o_pix.out_ch2, o_pix.out_ch1, o_pix.out_ch0})
);
